FILE: hdl/pfpr_pkg.sv
// ----------------------------------------------------------------------------
// pfpr_pkg
// Types, codes and sizes shared by the page frame replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package pfpr_pkg;

  localparam int FRAMES    = 16;
  localparam int ADDR_BITS = 32;
  localparam int USE_BITS  = 16;
  localparam int PIN_BITS  = 8;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
  localparam logic [USE_BITS-1:0] USE_MAX = {USE_BITS{1'b1}};

  // action codes
  localparam logic ACT_GET     = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // status codes
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_FILLED    = 3'd1;
  localparam logic [2:0] ST_EVICTED   = 3'd2;
  localparam logic [2:0] ST_ALL_PIN   = 3'd3;
  localparam logic [2:0] ST_RELEASED  = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic        action;
    logic [31:0] page_addr;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame_index;
    logic [31:0] writeback_addr;
  } out_t;

  // one frame entry as seen by the compare unit
  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] tag;
    logic [PIN_BITS-1:0]  pin;
    logic [USE_BITS-1:0]  use_cnt;
  } entry_t;

  // running victim candidate
  typedef struct packed {
    logic                have;
    logic                valid;
    logic [USE_BITS-1:0] use_cnt;
  } best_t;

  typedef struct packed {
    logic match;
    logic take;
  } cmp_t;

  function automatic logic [3:0] to_frame_index(input logic [IDX_W-1:0] idx);
    logic [31:0] t;
    t = 32'(idx);
    return t[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pfpr_cmp.sv
// ----------------------------------------------------------------------------
// pfpr_cmp
// Shared compare unit: tag match and victim ranking of one frame per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpr_cmp (
  input  wire pfpr_pkg::entry_t               entry,
  input  wire logic [pfpr_pkg::ADDR_BITS-1:0] addr,
  input  wire pfpr_pkg::best_t                best,
  output pfpr_pkg::cmp_t                      res
);

  always_comb begin
    res.match = entry.valid && (entry.tag == addr);
    res.take  = 1'b0;
    // only unpinned frames compete; once an empty frame is held it stays
    if (entry.pin == '0) begin
      if (!best.have) begin
        res.take = 1'b1;
      end else if (best.valid) begin
        res.take = !entry.valid || (entry.use_cnt < best.use_cnt);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/page_frame_pin_replace.sv
// ----------------------------------------------------------------------------
// page_frame_pin_replace
// Buffer pool frame table with pin counts and least-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req (action, page_addr) and raise start; the item
//   is taken at a clock edge where start is high and busy is low. busy stays
//   high until the result has been issued.
//   Result channel: done is high for exactly one cycle with result (status,
//   frame_index, writeback_addr) valid in that cycle. The receiver cannot
//   stall; it must take the result when done is high.
//   Sequence: after the accepting edge the sequencer walks all FRAMES entries
//   through one shared compare unit, one entry a cycle, then updates the
//   table in S_FINISH, where result and done are registered. A new item
//   can be accepted only once the previous result has been issued.
//   Reset: rst (synchronous, active high) marks every frame empty and
//   clears all pin and use counts; busy and done drop low.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_pin_replace (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire pfpr_pkg::in_t  req,
  output logic                done,
  output pfpr_pkg::out_t      result
);

  localparam int IW = pfpr_pkg::IDX_W;
  localparam int AW = pfpr_pkg::ADDR_BITS;
  localparam int UW = pfpr_pkg::USE_BITS;
  localparam int PW = pfpr_pkg::PIN_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(pfpr_pkg::FRAMES - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;

  // frame table
  logic [AW-1:0] tag_addr  [pfpr_pkg::FRAMES];
  logic          tag_valid [pfpr_pkg::FRAMES];
  logic [PW-1:0] pin_count [pfpr_pkg::FRAMES];
  logic [UW-1:0] use_count [pfpr_pkg::FRAMES];

  // latched item
  logic          action;
  logic [AW-1:0] addr;

  logic [IW-1:0] idx;

  // scan results
  logic          found;
  logic [IW-1:0] hit_idx;
  logic [PW-1:0] hit_pin;
  logic [UW-1:0] hit_use;
  pfpr_pkg::best_t best;
  logic [IW-1:0] best_idx;
  logic [AW-1:0] best_tag;

  pfpr_pkg::entry_t entry;
  pfpr_pkg::cmp_t   cmp;

  always_comb begin
    entry.valid   = tag_valid[idx];
    entry.tag     = tag_addr[idx];
    entry.pin     = pin_count[idx];
    entry.use_cnt = use_count[idx];
  end

  pfpr_cmp u_cmp (
    .entry (entry),
    .addr  (addr),
    .best  (best),
    .res   (cmp)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      idx   <= '0;
      found <= 1'b0;
      best  <= '0;
      for (int i = 0; i < pfpr_pkg::FRAMES; i++) begin
        tag_addr[i]  <= '0;
        tag_valid[i] <= 1'b0;
        pin_count[i] <= '0;
        use_count[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            action <= req.action;
            addr   <= AW'(req.page_addr);
            idx    <= '0;
            found  <= 1'b0;
            best   <= '0;
            state  <= S_SCAN;
          end
        end

        S_SCAN: begin
          done <= 1'b0;
          if (cmp.match && !found) begin
            found   <= 1'b1;
            hit_idx <= idx;
            hit_pin <= entry.pin;
            hit_use <= entry.use_cnt;
          end
          if (cmp.take) begin
            best.have    <= 1'b1;
            best.valid   <= entry.valid;
            best.use_cnt <= entry.use_cnt;
            best_idx     <= idx;
            best_tag     <= entry.tag;
          end
          if (idx == LAST_IDX) begin
            state <= S_FINISH;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_FINISH: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (action == pfpr_pkg::ACT_RELEASE) begin
            if (found) begin
              if (hit_pin != '0) begin
                pin_count[hit_idx] <= hit_pin - 1'b1;
              end
              result.status         <= pfpr_pkg::ST_RELEASED;
              result.frame_index    <= pfpr_pkg::to_frame_index(hit_idx);
              result.writeback_addr <= 32'(addr);
            end else begin
              result.status         <= pfpr_pkg::ST_NOT_FOUND;
              result.frame_index    <= '0;
              result.writeback_addr <= '0;
            end
          end else if (found) begin
            if (hit_pin != pfpr_pkg::PIN_MAX) begin
              pin_count[hit_idx] <= hit_pin + 1'b1;
            end
            if (hit_use != pfpr_pkg::USE_MAX) begin
              use_count[hit_idx] <= hit_use + 1'b1;
            end
            result.status         <= pfpr_pkg::ST_HIT;
            result.frame_index    <= pfpr_pkg::to_frame_index(hit_idx);
            result.writeback_addr <= '0;
          end else if (!best.have) begin
            result.status         <= pfpr_pkg::ST_ALL_PIN;
            result.frame_index    <= '0;
            result.writeback_addr <= '0;
          end else begin
            // reset use counts of the other valid frames, then load the victim
            for (int i = 0; i < pfpr_pkg::FRAMES; i++) begin
              if (tag_valid[i] && (IW'(i) != best_idx)) begin
                use_count[i] <= '0;
              end
            end
            tag_addr[best_idx]  <= addr;
            tag_valid[best_idx] <= 1'b1;
            use_count[best_idx] <= UW'(1);
            pin_count[best_idx] <= PW'(1);
            result.frame_index  <= pfpr_pkg::to_frame_index(best_idx);
            if (best.valid) begin
              result.status         <= pfpr_pkg::ST_EVICTED;
              result.writeback_addr <= 32'(best_tag);
            end else begin
              result.status         <= pfpr_pkg::ST_FILLED;
              result.writeback_addr <= '0;
            end
          end
        end

        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: verif/pfpr_checker.sv
// ----------------------------------------------------------------------------
// pfpr_checker
// Watches the request and result channels of the page frame table, keeps
// its own copy of tags, pin counts and use counts, predicts the result of
// every accepted item and compares it field by field with what comes back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pfpr_checker (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  input  wire             busy,
  input  pfpr_pkg::in_t   req,
  input  wire             done,
  input  pfpr_pkg::out_t  result,
  output int              fail_count,
  output int              pending_count
);

  logic [pfpr_pkg::ADDR_BITS-1:0] frame_tag [pfpr_pkg::FRAMES];
  logic                           frame_valid [pfpr_pkg::FRAMES];
  logic [pfpr_pkg::PIN_BITS-1:0]  frame_pin [pfpr_pkg::FRAMES];
  logic [pfpr_pkg::USE_BITS-1:0]  frame_use [pfpr_pkg::FRAMES];

  pfpr_pkg::out_t pending_results [$];

  initial fail_count = 0;
  initial pending_count = 0;

  // applies one item to the frame table copy and returns what the block reports
  function automatic pfpr_pkg::out_t next_frame_result(pfpr_pkg::in_t it);
    pfpr_pkg::out_t r;
    int hit;
    int vic;
    logic [pfpr_pkg::ADDR_BITS-1:0] a;
    logic [pfpr_pkg::ADDR_BITS-1:0] old_tag;
    logic was_valid;
    a = it.page_addr;
    r = '0;
    hit = -1;
    for (int i = 0; i < pfpr_pkg::FRAMES; i++) begin
      if (hit < 0 && frame_valid[i] && frame_tag[i] == a) hit = i;
    end

    if (it.action == pfpr_pkg::ACT_RELEASE) begin
      if (hit < 0) begin
        r.status = pfpr_pkg::ST_NOT_FOUND;
      end else begin
        if (frame_pin[hit] != 0) frame_pin[hit] = frame_pin[hit] - 1'b1;
        r.status = pfpr_pkg::ST_RELEASED;
        r.frame_index = 4'(hit);
        r.writeback_addr = a;
      end
      return r;
    end

    if (hit >= 0) begin
      if (frame_pin[hit] != pfpr_pkg::PIN_MAX) frame_pin[hit] = frame_pin[hit] + 1'b1;
      if (frame_use[hit] != pfpr_pkg::USE_MAX) frame_use[hit] = frame_use[hit] + 1'b1;
      r.status = pfpr_pkg::ST_HIT;
      r.frame_index = 4'(hit);
      return r;
    end

    // empty frames win, then the lowest use count, ties to the lowest index
    vic = -1;
    for (int i = 0; i < pfpr_pkg::FRAMES; i++) begin
      if (frame_pin[i] != 0) continue;
      if (vic < 0) begin
        vic = i;
      end else if (frame_valid[vic]) begin
        if (!frame_valid[i] || frame_use[i] < frame_use[vic]) vic = i;
      end
    end
    if (vic < 0) begin
      r.status = pfpr_pkg::ST_ALL_PIN;
      return r;
    end

    was_valid = frame_valid[vic];
    old_tag = frame_tag[vic];
    frame_tag[vic] = a;
    frame_valid[vic] = 1'b1;
    for (int i = 0; i < pfpr_pkg::FRAMES; i++) begin
      if (frame_valid[i]) frame_use[i] = '0;
    end
    frame_use[vic] = pfpr_pkg::USE_BITS'(1);
    frame_pin[vic] = pfpr_pkg::PIN_BITS'(1);
    r.frame_index = 4'(vic);
    if (was_valid) begin
      r.status = pfpr_pkg::ST_EVICTED;
      r.writeback_addr = old_tag;
    end else begin
      r.status = pfpr_pkg::ST_FILLED;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pfpr_pkg::out_t want;
    if (rst) begin
      for (int i = 0; i < pfpr_pkg::FRAMES; i++) begin
        frame_tag[i] = '0;
        frame_valid[i] = 1'b0;
        frame_pin[i] = '0;
        frame_use[i] = '0;
      end
      pending_results.delete();
    end else begin
      // retire first: a new item may be taken at the edge that ends a result
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no item outstanding: %p", $time, result);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, result.status);
            fail_count++;
          end
          if (result.frame_index !== want.frame_index) begin
            $display("%0t: frame_index mismatch: expected %0d, actual %0d",
                     $time, want.frame_index, result.frame_index);
            fail_count++;
          end
          if (result.writeback_addr !== want.writeback_addr) begin
            $display("%0t: writeback_addr mismatch: expected %h, actual %h",
                     $time, want.writeback_addr, result.writeback_addr);
            fail_count++;
          end
        end
      end
      if (start && !busy) pending_results.push_back(next_frame_result(req));
    end
    pending_count <= pending_results.size();
  end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives gets and releases into the page frame table: a directed opening
// through empty, hit, release and all-pinned cases, a run of hits that
// saturates the pin count, then random traffic over a small page
// pool under changing sender gaps. The checker decides pass or fail.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int POOL = 24;
  localparam int PHASE_ITEMS = 60;
  localparam int HAMMER_HITS = 258;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  pfpr_pkg::in_t  req;
  logic           done;
  pfpr_pkg::out_t result;
  int             fail_count;
  int             pending_count;

  logic [31:0] page_pool [POOL];

  page_frame_pin_replace dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  pfpr_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .done          (done),
    .result        (result),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // offers one item, waits for it to be taken, then idles at random
  task automatic send_item(input logic act, input logic [31:0] addr, input int idle_pct);
    pfpr_pkg::in_t it;
    it.action = act;
    it.page_addr = addr;
    req <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold off until every outstanding item has returned its result
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    int idle_pct;
    int get_pct;
    logic [31:0] addr;
    logic [31:0] hammer_addr;
    logic act;

    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening
    send_item(pfpr_pkg::ACT_RELEASE, 32'h0000_0000, 0);   // invalid tag of zero must not match
    send_item(pfpr_pkg::ACT_GET, 32'h0000_0000, 0);
    send_item(pfpr_pkg::ACT_GET, 32'hFFFF_FFFF, 0);
    send_item(pfpr_pkg::ACT_GET, 32'h0000_0000, 0);
    // last one hits an unpinned frame
    repeat (3) send_item(pfpr_pkg::ACT_RELEASE, 32'h0000_0000, 0);
    for (int k = 1; k <= 14; k++) send_item(pfpr_pkg::ACT_GET, k * 32'h0101_0101, 0);
    send_item(pfpr_pkg::ACT_GET, 32'h0000_0000, 0);        // hit on the unpinned frame
    send_item(pfpr_pkg::ACT_RELEASE, 32'h0000_0000, 0);
    send_item(pfpr_pkg::ACT_GET, 32'hDEAD_BEEF, 0);        // evicts the only unpinned frame
    send_item(pfpr_pkg::ACT_GET, 32'h7654_3210, 0);        // every frame pinned
    send_item(pfpr_pkg::ACT_RELEASE, 32'hFFFF_FFFF, 0);
    hammer_addr = 32'hA5C3_0F69;
    send_item(pfpr_pkg::ACT_GET, hammer_addr, 0);
    drain_results();

    // run of hits drives the pin count to its ceiling, releases bring it down to zero and hold it there
    for (int n = 0; n < HAMMER_HITS; n++) send_item(pfpr_pkg::ACT_GET, hammer_addr, 0);
    for (int n = 0; n < 258; n++) send_item(pfpr_pkg::ACT_RELEASE, hammer_addr, 0);
    drain_results();

    page_pool[0] = 32'h0000_0000;
    page_pool[1] = 32'hFFFF_FFFF;
    page_pool[2] = hammer_addr;
    page_pool[3] = 32'hDEAD_BEEF;
    for (int k = 4; k < POOL; k++) page_pool[k] = $urandom;

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 29 : (ph == 1) ? 88 : 0;
      get_pct = 65;
      drain_results();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // swing between get-heavy and release-heavy stretches so pins rise and fall
        if (n % 50 == 0) begin
          get_pct = (get_pct == 65) ? 35 : 65;
          if ($urandom_range(2) == 0) drain_results();
        end
        if ($urandom_range(9) == 0) addr = $urandom;
        else addr = page_pool[$urandom_range(POOL - 1)];
        act = ($urandom_range(99) < get_pct) ? pfpr_pkg::ACT_GET : pfpr_pkg::ACT_RELEASE;
        send_item(act, addr, idle_pct);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
